// ===== hw/rtl/fixed_point_line_rasterizer_defines.svh =====
// assertion macros for the fixed point line rasterizer checker
// needs clock and reset in scope where a macro is used
`ifndef FIXED_POINT_LINE_RASTERIZER_DEFINES_SVH
`define FIXED_POINT_LINE_RASTERIZER_DEFINES_SVH

// same cycle implication
`define FPLR_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fplr check failed");

// next cycle implication
`define FPLR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fplr check failed");

`endif

// ===== hw/rtl/fplr_pkg.sv =====
// shared constants, types and state encoding of the line rasterizer
// used by the controller, datapath, top level and checker
package fplr_pkg;

   localparam int COORD_W    = 10;
   localparam int COLOR_W    = 16;
   localparam int ADDR_W     = 20;
   localparam int FRAC_BITS  = 16;
   localparam int SCREEN_W   = 1024;
   localparam int ACC_W      = FRAC_BITS + COORD_W;
   localparam int REM_W      = COORD_W + 1;
   localparam int DIV_STEPS  = ACC_W;
   localparam int CNT_W      = $clog2(DIV_STEPS + 1);

   localparam int REQ_RAW_W  = 4 * COORD_W + COLOR_W;
   localparam int REQ_DATA_W = ((REQ_RAW_W + 7) / 8) * 8;
   localparam int RSP_RAW_W  = 2 * COORD_W + ADDR_W + COLOR_W;
   localparam int RSP_DATA_W = ((RSP_RAW_W + 7) / 8) * 8;

   localparam logic KIND_LINE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // one half in the accumulator fraction
   localparam logic [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (FRAC_BITS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_ACTIVE
   } fplr_state_type;

   typedef struct packed {
      logic load_line;
      logic div_step;
      logic div_finish;
      logic emit;
   } fplr_cmd_type;

   typedef struct packed {
      logic last;
   } fplr_status_type;

endpackage

// ===== hw/rtl/fixed_point_line_rasterizer.sv =====
// top level of the fixed point line rasterizer: packs the stream channels
// depends on fplr_pkg, fplr_ctrl and fplr_datapath
//
// usage
// req channel: req_tuser low is a line command (endpoints and colour in
// req_tdata), req_tuser high is a tick that asks for the next pixel.
// rsp channel: one transfer per tick while a line is active, rsp_tlast
// marks the pixel at the second endpoint. a tick with no active line is
// taken and gives nothing. a line command replaces any active line.
// timing: a line command is taken in its transfer cycle, then the radix-2
// divider makes one quotient bit per cycle and a last step applies the
// sign; req_tready is low while the divider runs. the pixel of a tick
// sits in the output register in the cycle after the tick is taken,
// so pixels go out at one per clock while rsp_tready stays high.
// stall: with a pixel held and rsp_tready low, req_tready drops until the
// pixel is taken; the held pixel does not change.
// reset: synchronous, active high; clears the controller, no line active,
// rsp_tvalid low.
module fixed_point_line_rasterizer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // start_x, start_y, end_x, end_y, color
   input  logic [fplr_pkg::REQ_DATA_W-1:0] req_tdata,
   // kind
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // pixel_x, pixel_y, pixel_address, pixel_color
   output logic [fplr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);
   import fplr_pkg::*;

   fplr_cmd_type       cmd;
   fplr_status_type    status;
   logic [COORD_W-1:0] pixel_x, pixel_y;
   logic [ADDR_W-1:0]  pixel_address;
   logic [COLOR_W-1:0] pixel_color;

   fplr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd),
      .status     (status)
   );

   fplr_datapath u_datapath (
      .clock         (clock),
      .cmd           (cmd),
      .status        (status),
      .start_x       (req_tdata[COORD_W-1:0]),
      .start_y       (req_tdata[2*COORD_W-1:COORD_W]),
      .end_x         (req_tdata[3*COORD_W-1:2*COORD_W]),
      .end_y         (req_tdata[4*COORD_W-1:3*COORD_W]),
      .color         (req_tdata[REQ_RAW_W-1:4*COORD_W]),
      .pixel_x       (pixel_x),
      .pixel_y       (pixel_y),
      .pixel_address (pixel_address),
      .pixel_color   (pixel_color),
      .last_pixel    (rsp_tlast)
   );

   assign rsp_tdata = RSP_DATA_W'({pixel_color, pixel_address, pixel_y, pixel_x});

endmodule

// ===== hw/rtl/fplr_ctrl.sv =====
// controller state machine of the line rasterizer: handshakes and sequencing
// depends on fplr_pkg
module fplr_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_kind,
   output logic                      req_tready,
   input  logic                      rsp_tready,
   output logic                      rsp_tvalid,
   output fplr_pkg::fplr_cmd_type    cmd,
   input  fplr_pkg::fplr_status_type status
);
   import fplr_pkg::*;

   fplr_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE, ST_ACTIVE: begin
            req_tready = !rsp_valid_ff || rsp_tready;
         end
         ST_DIVIDE: begin
            if (cnt_ff == CNT_W'(DIV_STEPS)) begin
               cmd.div_finish = 1'b1;
               state_in       = ST_ACTIVE;
            end else begin
               cmd.div_step = 1'b1;
               cnt_in       = cnt_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      accept = req_tvalid && req_tready;
      if (accept) begin
         if (req_kind == KIND_LINE) begin
            cmd.load_line = 1'b1;
            cnt_in        = '0;
            state_in      = ST_DIVIDE;
         end else if (state_ff == ST_ACTIVE) begin
            cmd.emit = 1'b1;
            if (status.last) begin
               state_in = ST_IDLE;
            end
         end
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== hw/rtl/fplr_datapath.sv =====
// datapath of the line rasterizer: set-up, radix-2 restoring divider,
// major counter, minor accumulator and result register; depends on fplr_pkg
module fplr_datapath (
   input  logic                         clock,
   input  fplr_pkg::fplr_cmd_type       cmd,
   output fplr_pkg::fplr_status_type    status,
   input  logic [fplr_pkg::COORD_W-1:0] start_x,
   input  logic [fplr_pkg::COORD_W-1:0] start_y,
   input  logic [fplr_pkg::COORD_W-1:0] end_x,
   input  logic [fplr_pkg::COORD_W-1:0] end_y,
   input  logic [fplr_pkg::COLOR_W-1:0] color,
   output logic [fplr_pkg::COORD_W-1:0] pixel_x,
   output logic [fplr_pkg::COORD_W-1:0] pixel_y,
   output logic [fplr_pkg::ADDR_W-1:0]  pixel_address,
   output logic [fplr_pkg::COLOR_W-1:0] pixel_color,
   output logic                         last_pixel
);
   import fplr_pkg::*;

   // line state
   logic               y_major_ff, step_up_ff;
   logic [COORD_W-1:0] pos_ff, end_ff;
   logic [ACC_W-1:0]   accum_ff, step_ff;
   logic [COLOR_W-1:0] color_ff;
   // divider state
   logic [REM_W-1:0]   rem_ff;
   logic [ACC_W-1:0]   dvd_ff;
   logic [COORD_W-1:0] dvs_ff;
   logic               neg_ff, zero_ff;
   // result register
   logic [COORD_W-1:0] px_ff, py_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [COLOR_W-1:0] pcolor_ff;
   logic               last_ff;

   logic [COORD_W:0]   dx, dy, ndx, ndy;
   logic [COORD_W-1:0] adx, ady, maj_abs, min_abs, min0;
   logic               y_major_in, maj_sign, min_sign;
   logic [REM_W-1:0]   shifted;
   logic [REM_W:0]     trial;
   logic               qbit;
   logic [ACC_W-1:0]   quot_neg;
   logic [COORD_W-1:0] minor, px, py;
   logic [ADDR_W-1:0]  addr;
   logic               last;

   always_comb begin
      dx         = {1'b0, end_x} - {1'b0, start_x};
      dy         = {1'b0, end_y} - {1'b0, start_y};
      ndx        = -dx;
      ndy        = -dy;
      adx        = dx[COORD_W] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
      ady        = dy[COORD_W] ? ndy[COORD_W-1:0] : dy[COORD_W-1:0];
      y_major_in = ady > adx;
      maj_abs    = y_major_in ? ady : adx;
      min_abs    = y_major_in ? adx : ady;
      maj_sign   = y_major_in ? dy[COORD_W] : dx[COORD_W];
      min_sign   = y_major_in ? dx[COORD_W] : dy[COORD_W];
      min0       = y_major_in ? start_x : start_y;

      shifted  = {rem_ff[REM_W-2:0], dvd_ff[ACC_W-1]};
      trial    = {1'b0, shifted} - {2'b0, dvs_ff};
      qbit     = !trial[REM_W];
      quot_neg = -dvd_ff;

      minor = accum_ff[ACC_W-1:FRAC_BITS];
      px    = y_major_ff ? minor : pos_ff;
      py    = y_major_ff ? pos_ff : minor;
      addr  = ADDR_W'(px) + ADDR_W'(py) * ADDR_W'(SCREEN_W);
      last  = pos_ff == end_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_line) begin
         y_major_ff <= y_major_in;
         step_up_ff <= (maj_abs != '0) && !maj_sign;
         pos_ff     <= y_major_in ? start_y : start_x;
         end_ff     <= y_major_in ? end_y : end_x;
         accum_ff   <= {min0, FRAC_BITS'(0)} + ACC_HALF;
         color_ff   <= color;
         rem_ff     <= '0;
         dvd_ff     <= {min_abs, FRAC_BITS'(0)};
         dvs_ff     <= maj_abs;
         neg_ff     <= maj_sign ^ min_sign;
         zero_ff    <= maj_abs == '0;
      end
      if (cmd.div_step) begin
         rem_ff <= qbit ? trial[REM_W-1:0] : shifted;
         dvd_ff <= {dvd_ff[ACC_W-2:0], qbit};
      end
      if (cmd.div_finish) begin
         step_ff <= zero_ff ? '0 : (neg_ff ? quot_neg : dvd_ff);
      end
      if (cmd.emit) begin
         px_ff     <= px;
         py_ff     <= py;
         addr_ff   <= addr;
         pcolor_ff <= color_ff;
         last_ff   <= last;
         if (!last) begin
            if (step_up_ff) begin
               pos_ff   <= pos_ff + COORD_W'(1);
               accum_ff <= accum_ff + step_ff;
            end else begin
               pos_ff   <= pos_ff - COORD_W'(1);
               accum_ff <= accum_ff - step_ff;
            end
         end
      end
   end

   assign status.last   = last;
   assign pixel_x       = px_ff;
   assign pixel_y       = py_ff;
   assign pixel_address = addr_ff;
   assign pixel_color   = pcolor_ff;
   assign last_pixel    = last_ff;

endmodule

// ===== hw/rtl/fplr_checker.sv =====
// port level checks of the line rasterizer, bound to the top level
// depends on fplr_pkg and fixed_point_line_rasterizer_defines.svh
`include "fixed_point_line_rasterizer_defines.svh"

module fplr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [fplr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);
   import fplr_pkg::*;

   logic line_xfer, tick_xfer, addr_ok;

   assign line_xfer = req_tvalid && req_tready && (req_tuser == KIND_LINE);
   assign tick_xfer = req_tvalid && req_tready && (req_tuser == KIND_TICK);
   assign addr_ok   = rsp_tdata[2*COORD_W+ADDR_W-1:2*COORD_W] ==
                      ADDR_W'(rsp_tdata[COORD_W-1:0]) +
                      ADDR_W'(rsp_tdata[2*COORD_W-1:COORD_W]) * ADDR_W'(SCREEN_W);

   // held pixel stays valid, with rsp_tlast stable, until taken
   `FPLR_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tlast))
   // divider busy after a line command
   `FPLR_ASSERT_NEXT(a_div_busy, line_xfer, !req_tready)
   // a new pixel only follows a tick
   `FPLR_ASSERT_NOW(a_pixel_cause, $rose(rsp_tvalid), $past(tick_xfer))
   // address matches the coordinates
   `FPLR_ASSERT_NOW(a_addr, rsp_tvalid, addr_ok)

endmodule

bind fixed_point_line_rasterizer fplr_checker u_fplr_checker (.*);

// ===== bench/fixed_point_line_rasterizer_tb.sv =====
// self-checking bench for the fixed point line rasterizer: directed lines, then random
// draw and tick sequences under varying stream back-pressure, checked against a pixel predictor
// depends on fplr_pkg and the fixed_point_line_rasterizer top level
`timescale 1ns / 1ps

module fixed_point_line_rasterizer_tb;
   import fplr_pkg::*;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [ADDR_W-1:0]  addr;
      logic [COLOR_W-1:0] color;
      logic               last;
   } pixel_type;

   class pixel_scoreboard;
      bit                 line_active;
      bit                 y_major;
      bit                 step_up;
      int                 major_pos;
      int                 major_end;
      bit [31:0]          minor_accum;
      bit [31:0]          minor_step;
      bit [COLOR_W-1:0]   line_color;
      pixel_type          pending_pixels[$];
      int                 errors;

      task report_mismatch(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      // returns 1 when the transfer is a line command or a tick that draws
      function bit note_request(logic kind, logic [REQ_DATA_W-1:0] data);
         int                 x0, y0, x1, y1, dx, dy, adx, ady;
         int                 maj_len, min_len, maj0, min0;
         longint             quotient;
         bit [COORD_W-1:0]   minor_coord, major_coord;
         pixel_type          pix;
         if (kind == KIND_LINE) begin
            x0 = data[0 +: COORD_W];
            y0 = data[COORD_W +: COORD_W];
            x1 = data[2*COORD_W +: COORD_W];
            y1 = data[3*COORD_W +: COORD_W];
            dx = x1 - x0;
            dy = y1 - y0;
            adx = dx < 0 ? -dx : dx;
            ady = dy < 0 ? -dy : dy;
            y_major = ady > adx;
            maj_len = y_major ? dy : dx;
            min_len = y_major ? dx : dy;
            maj0 = y_major ? y0 : x0;
            min0 = y_major ? x0 : y0;
            if (maj_len == 0) begin
               quotient = 0;
            end else begin
               quotient = (longint'(min_len) * (longint'(1) << FRAC_BITS)) / longint'(maj_len);
            end
            minor_step = quotient[31:0];
            minor_accum = (32'(min0) << FRAC_BITS) + (32'd1 << (FRAC_BITS - 1));
            step_up = maj_len > 0;
            major_pos = maj0;
            major_end = maj0 + maj_len;
            line_color = data[4*COORD_W +: COLOR_W];
            line_active = 1'b1;
            return 1'b1;
         end
         if (!line_active) return 1'b0;
         minor_coord = minor_accum[FRAC_BITS +: COORD_W];
         major_coord = major_pos[COORD_W-1:0];
         pix.x = y_major ? minor_coord : major_coord;
         pix.y = y_major ? major_coord : minor_coord;
         pix.addr = ADDR_W'(int'(pix.x) + int'(pix.y) * SCREEN_W);
         pix.color = line_color;
         pix.last = (major_pos == major_end);
         pending_pixels.push_back(pix);
         if (pix.last) begin
            line_active = 1'b0;
         end else if (step_up) begin
            major_pos += 1;
            minor_accum += minor_step;
         end else begin
            major_pos -= 1;
            minor_accum -= minor_step;
         end
         return 1'b1;
      endfunction

      task check_pixel(logic [RSP_DATA_W-1:0] data, logic last);
         pixel_type want;
         if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("pixel %0h with none pending", data));
            return;
         end
         want = pending_pixels.pop_front();
         if (data[0 +: COORD_W] !== want.x)
            report_mismatch($sformatf("pixel_x got %0d want %0d", data[0 +: COORD_W], want.x));
         if (data[COORD_W +: COORD_W] !== want.y)
            report_mismatch($sformatf("pixel_y got %0d want %0d",
                                      data[COORD_W +: COORD_W], want.y));
         if (data[2*COORD_W +: ADDR_W] !== want.addr)
            report_mismatch($sformatf("pixel_address got %0h want %0h",
                                      data[2*COORD_W +: ADDR_W], want.addr));
         if (data[2*COORD_W+ADDR_W +: COLOR_W] !== want.color)
            report_mismatch($sformatf("pixel_color got %0h want %0h",
                                      data[2*COORD_W+ADDR_W +: COLOR_W], want.color));
         if (last !== want.last)
            report_mismatch($sformatf("last_pixel got %0b want %0b", last, want.last));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   pixel_scoreboard sb = new;
   int send_idle = 35;
   int recv_idle = 51;
   int counted = 0;

   fixed_point_line_rasterizer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_pixel(rsp_tdata, rsp_tlast);
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   task automatic send_item(logic kind, logic [REQ_DATA_W-1:0] data);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      counted += sb.note_request(kind, data);
   endtask

   task automatic draw_line(int sx, int sy, int ex, int ey, int color, int ticks);
      send_item(KIND_LINE, REQ_DATA_W'({COLOR_W'(color), COORD_W'(ey), COORD_W'(ex),
                                        COORD_W'(sy), COORD_W'(sx)}));
      repeat (ticks) send_item(KIND_TICK, REQ_DATA_W'({$urandom, $urandom}));
   endtask

   function automatic int clamp(int v, int hi);
      return v < 0 ? 0 : (v > hi ? hi : v);
   endfunction

   task automatic random_sequence();
      int pick, sx, sy, ex, ey, span, adx, ady, ticks;
      pick = $urandom_range(0, 99);
      sx = $urandom_range(0, 1023);
      sy = $urandom_range(0, 767);
      if (pick < 92) begin
         span = pick < 70 ? 16 : (pick < 80 ? 64 : 1023);
         ex = clamp(sx + int'($urandom_range(0, 2 * span)) - span, 1023);
         ey = clamp(sy + int'($urandom_range(0, 2 * span)) - span, 767);
         adx = ex > sx ? ex - sx : sx - ex;
         ady = ey > sy ? ey - sy : sy - ey;
         ticks = (adx > ady ? adx : ady) + 1;
         if (pick >= 80) begin
            // random tick count, so the line may be broken off early and replaced by the next command
            ticks = $urandom_range(0, 40);
         end else if ($urandom_range(0, 3) == 0) begin
            ticks += $urandom_range(1, 2);
         end
         draw_line(sx, sy, ex, ey, $urandom_range(0, 65535), ticks);
      end else begin
         repeat ($urandom_range(1, 3)) send_item(KIND_TICK, REQ_DATA_W'({$urandom, $urandom}));
      end
   endtask

   initial begin
      int goal;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // tick with no line, zero length line then a tick past its end
      send_item(KIND_TICK, '0);
      draw_line(0, 0, 0, 0, 16'h0000, 2);
      // equal spans, x stays major
      draw_line(0, 0, 3, 3, 16'hffff, 4);
      // y major stepping down to row 0, x major stepping down to column 0
      draw_line(2, 3, 1, 0, 16'ha5a5, 4);
      draw_line(3, 1, 0, 2, 16'h1234, 4);
      // full screen diagonal cut short by a corner point
      draw_line(1023, 0, 0, 767, 16'h5a5a, 2);
      draw_line(1023, 767, 1023, 767, 16'hffff, 1);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle = phase == 0 ? 35 : (phase == 1 ? 51 : 0);
         recv_idle = phase == 0 ? 51 : (phase == 1 ? 35 : 0);
         goal = counted + 633;
         while (counted < goal) random_sequence();
      end
      req_tvalid <= 1'b0;

      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.pending_pixels.size() != 0) sb.report_mismatch("pixels left pending");
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/fplr_pkg.sv
hw/rtl/fplr_ctrl.sv
hw/rtl/fplr_datapath.sv
hw/rtl/fixed_point_line_rasterizer.sv
hw/rtl/fplr_checker.sv
bench/fixed_point_line_rasterizer_tb.sv
